FILE: hw/rtl/eadv_pkg.sv
// ----------------------------------------------------------------------------
// eadv_pkg
// Shared types, constants and the CORDIC arctangent table for the
// attitude and position block.
// ----------------------------------------------------------------------------
package eadv_pkg;

   localparam int ANGLE_BITS_DEF    = 16;
   localparam int TRIG_ITER_DEF     = 16;
   localparam int ATAN_DEPTH        = 24;
   localparam int ATAN_IDX_BITS     = 5;
   localparam int Q30_BITS          = 32;
   localparam int CORDIC_BITS       = 34;

   localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN = 34'sh26DD3B6A;
   localparam logic signed [CORDIC_BITS-1:0] Q30_ONE     = 34'sh40000000;

   typedef logic signed [Q30_BITS-1:0] q30_type;

   typedef struct packed {
      logic    done;
      q30_type cos_val;
      q30_type sin_val;
   } trig_res_type;

   localparam logic [29:0] ATAN_TABLE [ATAN_DEPTH] = '{
      30'h20000000, 30'h12E4051D, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
      30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
      30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
      30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
      30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
   };

endpackage

FILE: hw/rtl/euler_angle_direction_vectors.sv
// ----------------------------------------------------------------------------
// euler_angle_direction_vectors
// Accumulates pitch, yaw and roll and a saturating position, then returns
// forward and right unit vectors and the position for every transaction.
//
//   channel | direction | tdata bits | contents
//   req     | in        | 112        | deltas, move vector, scale
//   rsp     | out       | 192        | forward, right, position
//
// after acceptance the result is built in order: the position update, three cordic
// passes (iterations capped at 24), ten multiplier steps and the packing step into
// the output register.
// reset is synchronous and clears angles and position.
// req_tready is low from acceptance until the result enters the output
// register; a result still waiting there holds the next one in the last step.
// ----------------------------------------------------------------------------
module euler_angle_direction_vectors
   import eadv_pkg::*;
#(
   parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
   parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pitch_delta, yaw_delta, roll_delta, move_x, move_y, move_z, move_scale
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // forward_x/y/z, right_x/y/z (16 each), position_x/y/z (32 each)
   output logic [191:0] rsp_tdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_POS  = 3'd1;
   localparam logic [2:0] S_TRIG = 3'd2;
   localparam logic [2:0] S_PROD = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   localparam logic [1:0] TRIG_PITCH = 2'd0;
   localparam logic [1:0] TRIG_YAW   = 2'd1;
   localparam logic [1:0] TRIG_ROLL  = 2'd2;

   localparam logic [3:0] ST_SYSP = 4'd0;
   localparam logic [3:0] ST_CYSP = 4'd1;
   localparam logic [3:0] ST_SYCP = 4'd2;
   localparam logic [3:0] ST_CYCP = 4'd3;
   localparam logic [3:0] ST_CYCR = 4'd4;
   localparam logic [3:0] ST_SYCR = 4'd5;
   localparam logic [3:0] ST_CPSR = 4'd6;
   localparam logic [3:0] ST_SYSPSR = 4'd7;
   localparam logic [3:0] ST_CYSPSR = 4'd8;
   localparam logic [3:0] ST_LAST = 4'd9;

   logic [2:0]            state_ff, state_in;
   logic [1:0]            sel_ff, sel_in;
   logic                  wait_ff, wait_in;
   logic [3:0]            step_ff, step_in;
   logic [ANGLE_BITS-1:0] pitch_ff, pitch_in, yaw_ff, yaw_in, roll_ff, roll_in;
   logic signed [31:0]    pos_ff [3];
   logic signed [31:0]    pos_in [3];
   logic signed [15:0]    mv_ff [3];
   logic signed [15:0]    mv_in [3];
   logic signed [15:0]    scale_ff, scale_in;
   q30_type               cp_ff, sp_ff, cy_ff, sy_ff, cr_ff, sr_ff;
   q30_type               cp_in, sp_in, cy_in, sy_in, cr_in, sr_in;
   q30_type               p_sysp_ff, p_cysp_ff, p_sycp_ff, p_cycp_ff, p_cycr_ff;
   q30_type               p_sycr_ff, p_cpsr_ff, p_syspsr_ff, p_cyspsr_ff;
   q30_type               p_sysp_in, p_cysp_in, p_sycp_in, p_cycp_in, p_cycr_in;
   q30_type               p_sycr_in, p_cpsr_in, p_syspsr_in, p_cyspsr_in;
   logic                  out_valid_ff, out_valid_in;
   logic [191:0]          out_data_ff, out_data_in;

   logic                  req_fire, rsp_fire;
   logic                  trig_start;
   logic [ANGLE_BITS-1:0] trig_angle;
   trig_res_type          trig_res;
   q30_type               mul_a, mul_b, mul_res;
   logic [3:0]            cap_step;

   logic signed [31:0]    d32 [3];
   logic signed [31:0]    mprod;
   logic signed [32:0]    psum;

   function automatic logic [15:0] to_q14(input logic signed [33:0] v);
      logic signed [33:0] r;
      begin
         r = (v + 34'sh8000) >>> 16;
         if (r > 34'sh4000) r = 34'sh4000;
         if (r < -34'sh4000) r = -34'sh4000;
         to_q14 = r[15:0];
      end
   endfunction

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = out_valid_ff && rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   eadv_cordic #(
      .ANGLE_BITS      (ANGLE_BITS),
      .TRIG_ITERATIONS (TRIG_ITERATIONS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (trig_start),
      .angle  (trig_angle),
      .result (trig_res)
   );

   eadv_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_res)
   );

   always_comb begin
      trig_start = (state_ff == S_TRIG) && !wait_ff;
      case (sel_ff)
         TRIG_PITCH: trig_angle = pitch_ff;
         TRIG_YAW:   trig_angle = yaw_ff;
         default:    trig_angle = roll_ff;
      endcase

      case (step_ff)
         ST_SYSP:   begin mul_a = sy_ff;       mul_b = sp_ff; end
         ST_CYSP:   begin mul_a = cy_ff;       mul_b = sp_ff; end
         ST_SYCP:   begin mul_a = sy_ff;       mul_b = cp_ff; end
         ST_CYCP:   begin mul_a = cy_ff;       mul_b = cp_ff; end
         ST_CYCR:   begin mul_a = cy_ff;       mul_b = cr_ff; end
         ST_SYCR:   begin mul_a = sy_ff;       mul_b = cr_ff; end
         ST_CPSR:   begin mul_a = cp_ff;       mul_b = sr_ff; end
         ST_SYSPSR: begin mul_a = p_sysp_ff;   mul_b = sr_ff; end
         ST_CYSPSR: begin mul_a = p_cysp_ff;   mul_b = sr_ff; end
         default:   begin mul_a = '0;          mul_b = '0;    end
      endcase
      cap_step = step_ff - 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      wait_in      = wait_ff;
      step_in      = step_ff;
      pitch_in     = pitch_ff;
      yaw_in       = yaw_ff;
      roll_in      = roll_ff;
      scale_in     = scale_ff;
      cp_in        = cp_ff;
      sp_in        = sp_ff;
      cy_in        = cy_ff;
      sy_in        = sy_ff;
      cr_in        = cr_ff;
      sr_in        = sr_ff;
      p_sysp_in    = p_sysp_ff;
      p_cysp_in    = p_cysp_ff;
      p_sycp_in    = p_sycp_ff;
      p_cycp_in    = p_cycp_ff;
      p_cycr_in    = p_cycr_ff;
      p_sycr_in    = p_sycr_ff;
      p_cpsr_in    = p_cpsr_ff;
      p_syspsr_in  = p_syspsr_ff;
      p_cyspsr_in  = p_cyspsr_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      mprod        = '0;
      psum         = '0;
      for (int k = 0; k < 3; k++) begin
         pos_in[k] = pos_ff[k];
         mv_in[k]  = mv_ff[k];
         d32[k]    = 32'(signed'(req_tdata[16*k +: 16]));
      end

      if (rsp_fire) out_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pitch_in = pitch_ff + d32[0][ANGLE_BITS-1:0];
               yaw_in   = yaw_ff + d32[1][ANGLE_BITS-1:0];
               roll_in  = roll_ff + d32[2][ANGLE_BITS-1:0];
               for (int k = 0; k < 3; k++) begin
                  mv_in[k] = signed'(req_tdata[48 + 16*k +: 16]);
               end
               scale_in = signed'(req_tdata[111:96]);
               state_in = S_POS;
            end
         end
         S_POS: begin
            for (int k = 0; k < 3; k++) begin
               mprod = 32'(mv_ff[k]) * 32'(scale_ff);
               psum  = 33'(pos_ff[k]) + 33'(mprod);
               if (psum[32] != psum[31]) begin
                  pos_in[k] = psum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
               end else begin
                  pos_in[k] = psum[31:0];
               end
            end
            sel_in   = TRIG_PITCH;
            wait_in  = 1'b0;
            state_in = S_TRIG;
         end
         S_TRIG: begin
            if (trig_start) wait_in = 1'b1;
            if (trig_res.done) begin
               wait_in = 1'b0;
               case (sel_ff)
                  TRIG_PITCH: begin cp_in = trig_res.cos_val; sp_in = trig_res.sin_val; end
                  TRIG_YAW:   begin cy_in = trig_res.cos_val; sy_in = trig_res.sin_val; end
                  default:    begin cr_in = trig_res.cos_val; sr_in = trig_res.sin_val; end
               endcase
               if (sel_ff == TRIG_ROLL) begin
                  step_in  = ST_SYSP;
                  state_in = S_PROD;
               end else begin
                  sel_in = sel_ff + 1'b1;
               end
            end
         end
         S_PROD: begin
            if (step_ff != ST_SYSP) begin
               case (cap_step)
                  ST_SYSP:   p_sysp_in   = mul_res;
                  ST_CYSP:   p_cysp_in   = mul_res;
                  ST_SYCP:   p_sycp_in   = mul_res;
                  ST_CYCP:   p_cycp_in   = mul_res;
                  ST_CYCR:   p_cycr_in   = mul_res;
                  ST_SYCR:   p_sycr_in   = mul_res;
                  ST_CPSR:   p_cpsr_in   = mul_res;
                  ST_SYSPSR: p_syspsr_in = mul_res;
                  default:   p_cyspsr_in = mul_res;
               endcase
            end
            if (step_ff == ST_LAST) begin
               state_in = S_FIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_FIN: begin
            if (!out_valid_ff || rsp_fire) begin
               out_data_in[15:0]    = to_q14(-34'(p_sycp_ff));
               out_data_in[31:16]   = to_q14(34'(p_cycp_ff));
               out_data_in[47:32]   = to_q14(-34'(sp_ff));
               out_data_in[63:48]   = to_q14(34'(p_cycr_ff) + 34'(p_syspsr_ff));
               out_data_in[79:64]   = to_q14(34'(p_sycr_ff) - 34'(p_cyspsr_ff));
               out_data_in[95:80]   = to_q14(34'(p_cpsr_ff));
               out_data_in[127:96]  = pos_ff[0];
               out_data_in[159:128] = pos_ff[1];
               out_data_in[191:160] = pos_ff[2];
               out_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= TRIG_PITCH;
         wait_ff      <= 1'b0;
         step_ff      <= ST_SYSP;
         out_valid_ff <= 1'b0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
         roll_ff      <= '0;
         for (int k = 0; k < 3; k++) pos_ff[k] <= '0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         wait_ff      <= wait_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
         roll_ff      <= roll_in;
         for (int k = 0; k < 3; k++) pos_ff[k] <= pos_in[k];
      end
      for (int k = 0; k < 3; k++) mv_ff[k] <= mv_in[k];
      scale_ff    <= scale_in;
      cp_ff       <= cp_in;
      sp_ff       <= sp_in;
      cy_ff       <= cy_in;
      sy_ff       <= sy_in;
      cr_ff       <= cr_in;
      sr_ff       <= sr_in;
      p_sysp_ff   <= p_sysp_in;
      p_cysp_ff   <= p_cysp_in;
      p_sycp_ff   <= p_sycp_in;
      p_cycp_ff   <= p_cycp_in;
      p_cycr_ff   <= p_cycr_in;
      p_sycr_ff   <= p_sycr_in;
      p_cpsr_ff   <= p_cpsr_in;
      p_syspsr_ff <= p_syspsr_in;
      p_cyspsr_ff <= p_cyspsr_in;
      out_data_ff <= out_data_in;
   end

`ifndef SYNTHESIS
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pending result changed before it was taken");

   a_accept_to_pos: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_POS))
      else $error("accepted transaction did not start position update");

   a_done_in_trig: assert property (@(posedge clock) disable iff (reset)
      trig_res.done |-> (state_ff == S_TRIG) && wait_ff)
      else $error("cordic finished outside a trig pass");

   a_fin_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) && (!out_valid_ff || rsp_tready) |=> req_tready && rsp_tvalid)
      else $error("finished result was not loaded");
`endif

endmodule

FILE: hw/rtl/eadv_mul.sv
// ----------------------------------------------------------------------------
// eadv_mul
// Shared Q30 multiplier: registered product rounded back to Q30.
// ----------------------------------------------------------------------------
module eadv_mul
   import eadv_pkg::*;
(
   input  logic    clock,
   input  q30_type op_a,
   input  q30_type op_b,
   output q30_type prod_ff
);

   logic signed [63:0] full_prod;
   logic signed [63:0] rounded;
   q30_type            prod_in;

   always_comb begin
      full_prod = 64'(op_a) * 64'(op_b);
      rounded   = (full_prod + 64'sh20000000) >>> 30;
      prod_in   = rounded[Q30_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: hw/rtl/eadv_cordic.sv
// ----------------------------------------------------------------------------
// eadv_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving the
// clamped Q30 cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
module eadv_cordic
   import eadv_pkg::*;
#(
   parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
   parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ANGLE_BITS-1:0] angle,
   output trig_res_type          result
);

   localparam int ITER      = (TRIG_ITERATIONS < ATAN_DEPTH) ? TRIG_ITERATIONS : ATAN_DEPTH;
   localparam int ITER_BITS = $clog2(ITER);

   logic signed [CORDIC_BITS-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [ITER_BITS-1:0]          i_ff, i_in;
   logic                          busy_ff, busy_in, fin_ff, fin_in, neg_ff, neg_in;
   logic                          done_ff, done_in;
   q30_type                       cos_ff, cos_in, sin_ff, sin_in;

   logic [31:0]                   t_wide;
   logic [31:0]                   t_fold;
   logic signed [CORDIC_BITS-1:0] dx, dy, atan_val, xn, yn;

   function automatic q30_type clamp30(input logic signed [CORDIC_BITS-1:0] v);
      logic signed [CORDIC_BITS-1:0] c;
      begin
         c = v;
         if (v > Q30_ONE) c = Q30_ONE;
         if (v < -Q30_ONE) c = -Q30_ONE;
         clamp30 = c[Q30_BITS-1:0];
      end
   endfunction

   always_comb begin
      t_wide   = {angle, {(32-ANGLE_BITS){1'b0}}};
      t_fold   = t_wide;
      if (t_wide[31] != t_wide[30]) t_fold[31] = ~t_wide[31];
      dx       = y_ff >>> i_ff;
      dy       = x_ff >>> i_ff;
      atan_val = CORDIC_BITS'(ATAN_TABLE[ATAN_IDX_BITS'(i_ff)]);
      xn       = -x_ff;
      yn       = -y_ff;

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      neg_in  = neg_ff;
      done_in = 1'b0;
      cos_in  = cos_ff;
      sin_in  = sin_ff;

      if (start && !busy_ff) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = CORDIC_BITS'(signed'(t_fold));
         i_in    = '0;
         busy_in = 1'b1;
         neg_in  = (t_wide[31] != t_wide[30]);
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_BITS-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_val;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == ITER_BITS'(ITER - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end

      if (fin_ff) begin
         done_in = 1'b1;
         cos_in  = neg_ff ? clamp30(xn) : clamp30(x_ff);
         sin_in  = neg_ff ? clamp30(yn) : clamp30(y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         i_ff    <= i_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign result.done    = done_ff;
   assign result.cos_val = cos_ff;
   assign result.sin_val = sin_ff;

endmodule
